// ===== hdl/u8d_pkg.sv =====
package u8d_pkg;

	// byte classes and limits
	localparam logic [7:0] AsciiLimit = 8'h80;
	localparam logic [7:0] LeadMin    = 8'hC2;
	localparam logic [7:0] Lead3      = 8'hE0;
	localparam logic [7:0] Lead4      = 8'hF0;
	localparam logic [7:0] LeadF4     = 8'hF4;
	localparam logic [7:0] LeadLimit  = 8'hF5;
	localparam logic [7:0] ContMask   = 8'hC0;
	localparam logic [7:0] ContTag    = 8'h80;
	localparam logic [7:0] E0SecMin   = 8'hA0;
	localparam logic [7:0] F0SecMin   = 8'h90;
	localparam logic [7:0] F4SecLimit = 8'h90;
	localparam logic [7:0] EscHigh    = 8'hDC;

	localparam int CpW        = 21;
	localparam int JobSlots   = 4;
	localparam int CntW       = $clog2(JobSlots + 1);
	localparam int QueueDepth = 4;
	localparam int QPtrW      = $clog2(QueueDepth);
	localparam int QLvlW      = $clog2(QueueDepth + 1);

	// one result word
	typedef struct packed {
		logic [CpW-1:0] cp;
		logic           esc;
	} ent_t;

	// all results caused by one input byte
	typedef struct packed {
		ent_t [JobSlots-1:0] ent;
		logic [CntW-1:0]     cnt;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// escape word for an invalid byte: 0xDC00 + byte
	function automatic ent_t esc_ent(input logic [7:0] b);
		ent_t e;
		e.cp  = {5'b0, EscHigh, b};
		e.esc = 1'b1;
		return e;
	endfunction

endpackage

// ===== hdl/u8d_front.sv =====
module u8d_front import u8d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] in_byte,
	input  logic       in_end,
	input  q_status_t  q_stat,
	output logic       in_ready,
	output logic       push,
	output job_t       job
);

	logic [7:0] lead_q, second_q, third_q;
	logic [1:0] held_q;
	logic [2:0] len_q;

	logic [7:0] lead_d, second_d, third_d;
	logic [1:0] held_d;
	logic [2:0] len_d;

	logic       accept;
	logic       cont_ok;
	logic       rule_bad;
	logic [CpW-1:0] seq_cp;

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && (job.cnt != '0);

	// continuation check, with the second-byte range rules
	always_comb begin
		rule_bad = 1'b0;
		if (held_q == 2'd1) begin
			if (lead_q == Lead3  && in_byte <  E0SecMin)   rule_bad = 1'b1;
			if (lead_q == Lead4  && in_byte <  F0SecMin)   rule_bad = 1'b1;
			if (lead_q == LeadF4 && in_byte >= F4SecLimit) rule_bad = 1'b1;
		end
		cont_ok = ((in_byte & ContMask) == ContTag) && !rule_bad;
	end

	// assemble the code point of a completed sequence
	always_comb begin
		case (len_q)
			3'd2:    seq_cp = {10'b0, lead_q[4:0], in_byte[5:0]};
			3'd3:    seq_cp = {5'b0, lead_q[3:0], second_q[5:0], in_byte[5:0]};
			default: seq_cp = {lead_q[2:0], second_q[5:0], third_q[5:0], in_byte[5:0]};
		endcase
	end

	// build the result list and the next held state
	always_comb begin
		logic [CntW-1:0] n;
		logic            do_start;
		job      = '0;
		n        = '0;
		do_start = 1'b0;
		lead_d   = lead_q;
		second_d = second_q;
		third_d  = third_q;
		held_d   = held_q;
		len_d    = len_q;

		if (held_q == 2'd0) begin
			do_start = 1'b1;
		end else if (!cont_ok) begin
			// drop the pending sequence as escapes, then retry the byte as a fresh start
			job.ent[n[1:0]] = esc_ent(lead_q);
			n = n + 1'b1;
			if (held_q >= 2'd2) begin
				job.ent[n[1:0]] = esc_ent(second_q);
				n = n + 1'b1;
			end
			if (held_q == 2'd3) begin
				job.ent[n[1:0]] = esc_ent(third_q);
				n = n + 1'b1;
			end
			lead_d   = '0;
			second_d = '0;
			third_d  = '0;
			held_d   = '0;
			len_d    = '0;
			do_start = 1'b1;
		end else if ({1'b0, held_q} + 3'd1 < len_q) begin
			if (held_q == 2'd1) begin
				second_d = in_byte;
			end else begin
				third_d = in_byte;
			end
			held_d = held_q + 2'd1;
		end else begin
			job.ent[n[1:0]].cp  = seq_cp;
			job.ent[n[1:0]].esc = 1'b0;
			n = n + 1'b1;
			lead_d   = '0;
			second_d = '0;
			third_d  = '0;
			held_d   = '0;
			len_d    = '0;
		end

		if (do_start) begin
			if (in_byte < AsciiLimit) begin
				job.ent[n[1:0]].cp  = {13'b0, in_byte};
				job.ent[n[1:0]].esc = 1'b0;
				n = n + 1'b1;
			end else if (in_byte < LeadMin || in_byte >= LeadLimit) begin
				job.ent[n[1:0]] = esc_ent(in_byte);
				n = n + 1'b1;
			end else begin
				lead_d = in_byte;
				held_d = 2'd1;
				if (in_byte < Lead3) begin
					len_d = 3'd2;
				end else if (in_byte < Lead4) begin
					len_d = 3'd3;
				end else begin
					len_d = 3'd4;
				end
			end
		end

		// end of buffer: flush whatever is still held
		if (in_end && held_d != 2'd0) begin
			job.ent[n[1:0]] = esc_ent(lead_d);
			n = n + 1'b1;
			if (held_d >= 2'd2) begin
				job.ent[n[1:0]] = esc_ent(second_d);
				n = n + 1'b1;
			end
			if (held_d == 2'd3) begin
				job.ent[n[1:0]] = esc_ent(third_d);
				n = n + 1'b1;
			end
			lead_d   = '0;
			second_d = '0;
			third_d  = '0;
			held_d   = '0;
			len_d    = '0;
		end

		job.cnt = n;
	end

	// held sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q   <= '0;
			second_q <= '0;
			third_q  <= '0;
			held_q   <= '0;
			len_q    <= '0;
		end else if (accept) begin
			lead_q   <= lead_d;
			second_q <= second_d;
			third_q  <= third_d;
			held_q   <= held_d;
			len_q    <= len_d;
		end
	end

	// a held sequence always has a valid length for its fill
	a_len_ok: assert property (@(posedge clk) disable iff (!arst_n)
		held_q != 2'd0 |-> ({1'b0, held_q} < len_q && len_q <= 3'd4))
		else $error("held count does not fit sequence length");

endmodule

// ===== hdl/u8d_queue.sv =====
module u8d_queue import u8d_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  job_t      push_job,
	input  logic      pop,
	output job_t      head,
	output q_status_t stat
);

	job_t             slots_q [QueueDepth];
	logic [QPtrW-1:0] wr_q, rd_q;
	logic [QLvlW-1:0] level_q;

	assign stat.full  = (level_q == QLvlW'(QueueDepth));
	assign stat.empty = (level_q == '0);
	assign head       = slots_q[rd_q];

	// job storage
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= push_job;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10:   level_q <= level_q + 1'b1;
				2'b01:   level_q <= level_q - 1'b1;
				default: level_q <= level_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!stat.full || pop))
		else $error("job queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("job queue read while empty");

	a_no_empty_job: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> push_job.cnt != '0)
		else $error("empty job queued");

endmodule

// ===== hdl/u8d_back.sv =====
module u8d_back import u8d_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  job_t           head,
	input  q_status_t      q_stat,
	output logic           pop,
	input  logic           out_ready,
	output logic           out_valid,
	output logic [CpW-1:0] out_cp,
	output logic           out_esc,
	output logic           out_last
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic       load;
	logic       at_last;

	// step through the head job, one word per load
	assign load    = !q_stat.empty && (!valid_q || out_ready);
	assign at_last = ({1'b0, idx_q} + 3'd1) == head.cnt;
	assign pop     = load && at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= at_last ? 2'd0 : idx_q + 2'd1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (load) begin
			out_cp   <= head.ent[idx_q].cp;
			out_esc  <= head.ent[idx_q].esc;
			out_last <= at_last;
		end
	end

	assign out_valid = valid_q;

	a_idx_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		!q_stat.empty |-> ({1'b0, idx_q} < head.cnt))
		else $error("result index past end of job");

endmodule

// ===== hdl/utf8_stream_decoder_unit.sv =====
// UTF-8 stream decoder. Takes one raw byte per word (tlast marks the last byte of a buffer)
// and gives one code point per output word, with tuser set when the word is an escaped
// invalid byte (0xDC00 + byte) and tlast set on the final word caused by an input byte.
// Bytes that only extend a pending sequence give no output word. Input is taken every
// cycle while the four-entry job queue has room; each input byte produces 0 to 4 words,
// and the output serialiser gives one word per cycle while m_tready is high, so the
// sustained rate is one byte per cycle for valid text. An accepted byte's words pass
// through a job queue slot register and then the output word register.
module utf8_stream_decoder_unit import u8d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // end_of_input
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
	output logic [0:0]  m_tuser,   // [0] is_escape
	output logic        m_tlast    // last_of_run
);

	job_t           job, head;
	q_status_t      q_stat;
	logic           push, pop;
	logic [CpW-1:0] cp;
	logic           esc;

	u8d_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_byte  (s_tdata),
		.in_end   (s_tlast),
		.q_stat   (q_stat),
		.in_ready (s_tready),
		.push     (push),
		.job      (job)
	);

	u8d_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (job),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	u8d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_cp    (cp),
		.out_esc   (esc),
		.out_last  (m_tlast)
	);

	assign m_tdata = {3'b0, cp};
	assign m_tuser = esc;

endmodule

// ===== tb/sv/utf8_decode_checker.sv =====
module utf8_decode_checker import u8d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] in_byte
	input  logic        s_tlast,    // end_of_input
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,    // [20:0] code_point, [23:21] zero
	input  logic [0:0]  m_tuser,    // [0] is_escape
	input  logic        m_tlast,    // last_of_run
	output int          mismatches,
	output int          outstanding
);

	// one output word as the decoder should give it
	typedef struct packed {
		logic [CpW-1:0] cp;
		logic           esc;
		logic           last;
	} cp_word_t;

	cp_word_t expected_words[$];
	cp_word_t step_words[$];
	cp_word_t want;

	// held part of an unfinished sequence
	logic [7:0] lead_b;
	logic [7:0] second_b;
	logic [7:0] third_b;
	logic [1:0] held;
	logic [2:0] seq_len;

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	function automatic logic [CpW-1:0] escape_of(input logic [7:0] b);
		return {5'b0, EscHigh, b};
	endfunction

	function automatic void add_word(input logic [CpW-1:0] cp, input logic esc);
		cp_word_t w;
		w.cp   = cp;
		w.esc  = esc;
		w.last = 1'b0;
		step_words.insert(step_words.size(), w);
	endfunction

	function automatic void clear_held();
		lead_b   = '0;
		second_b = '0;
		third_b  = '0;
		held     = '0;
		seq_len  = '0;
	endfunction

	// escape every held byte, oldest first, and forget the sequence
	function automatic void drop_pending();
		if (held >= 2'd1) add_word(escape_of(lead_b), 1'b1);
		if (held >= 2'd2) add_word(escape_of(second_b), 1'b1);
		if (held >= 2'd3) add_word(escape_of(third_b), 1'b1);
		clear_held();
	endfunction

	// byte seen with nothing pending: ASCII, bad lead or start of a sequence
	function automatic void begin_byte(input logic [7:0] b);
		if (b < AsciiLimit) begin
			add_word({13'b0, b}, 1'b0);
		end else if (b < LeadMin || b >= LeadLimit) begin
			add_word(escape_of(b), 1'b1);
		end else begin
			lead_b  = b;
			held    = 2'd1;
			seq_len = (b < Lead3) ? 3'd2 : (b < Lead4) ? 3'd3 : 3'd4;
		end
	endfunction

	// words caused by one accepted byte, queued in output order
	function automatic void decode_byte(input logic [7:0] b, input logic eoi);
		logic           cont_good;
		logic [CpW-1:0] cp;
		cp_word_t       w;
		step_words.delete();
		if (held == 2'd0) begin
			begin_byte(b);
		end else begin
			cont_good = ((b & ContMask) == ContTag);
			// second byte range limits: overlong forms and values past U+10FFFF
			if (held == 2'd1) begin
				if (lead_b == Lead3 && b < E0SecMin) cont_good = 1'b0;
				if (lead_b == Lead4 && b < F0SecMin) cont_good = 1'b0;
				if (lead_b == LeadF4 && b >= F4SecLimit) cont_good = 1'b0;
			end
			if (!cont_good) begin
				drop_pending();
				begin_byte(b);
			end else if (held + 1 < seq_len) begin
				if (held == 2'd1) second_b = b;
				else third_b = b;
				held = held + 2'd1;
			end else begin
				case (seq_len)
					3'd2: cp = {10'b0, lead_b[4:0], b[5:0]};
					3'd3: cp = {5'b0, lead_b[3:0], second_b[5:0], b[5:0]};
					default: cp = {lead_b[2:0], second_b[5:0], third_b[5:0], b[5:0]};
				endcase
				clear_held();
				add_word(cp, 1'b0);
			end
		end
		if (eoi) drop_pending();
		for (int i = 0; i < step_words.size(); i++) begin
			w = step_words[i];
			w.last = (i == step_words.size() - 1);
			expected_words.insert(expected_words.size(), w);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_words.delete();
			clear_held();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			// output word against the oldest expectation
			if (m_tvalid && m_tready) begin
				if (expected_words.size() == 0) begin
					report_mismatch($sformatf("word %h with none expected", m_tdata));
				end else begin
					want = expected_words.pop_front();
					if (m_tdata[CpW-1:0] !== want.cp)
						report_mismatch($sformatf("code point %h, want %h",
							m_tdata[CpW-1:0], want.cp));
					if (m_tdata[23:CpW] !== '0)
						report_mismatch($sformatf("padding bits %b", m_tdata[23:CpW]));
					if (m_tuser[0] !== want.esc)
						report_mismatch($sformatf("escape flag %b, want %b on %h",
							m_tuser[0], want.esc, want.cp));
					if (m_tlast !== want.last)
						report_mismatch($sformatf("tlast %b, want %b on %h",
							m_tlast, want.last, want.cp));
				end
			end
			// input word: predict what it causes
			if (s_tvalid && s_tready)
				decode_byte(s_tdata, s_tlast);
			outstanding <= expected_words.size();
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
	import u8d_pkg::*;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [7:0]  s_tdata  = '0;   // [7:0] in_byte
	logic        s_tlast  = 1'b0; // end_of_input
	logic        m_tready = 1'b0;
	wire         s_tready;
	wire         m_tvalid;
	wire  [23:0] m_tdata;         // [20:0] code_point, [23:21] zero
	wire  [0:0]  m_tuser;         // [0] is_escape
	wire         m_tlast;         // last_of_run

	int mismatches;
	int outstanding;
	int sent = 0;

	logic steady       = 1'b0;   // no idling on either side
	logic hold_off_req = 1'b0;   // receiver to back off for a long stretch

	logic [8:0] pending_bytes[$];   // {end_of_input, byte}

	always #1 clk = ~clk;

	utf8_stream_decoder_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	utf8_decode_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		logic held_off;
		held_off = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_req && !held_off) begin
				held_off = 1'b1;
				m_tready <= 1'b0;
				repeat (150) @(posedge clk);
			end else begin
				m_tready <= steady || ($urandom_range(99) >= 30);
			end
		end
	end

	// hard stop
	initial begin
		#400000;
		$display("status: fail");
		$finish;
	end

	// offer one byte, idling first now and then
	task automatic push_byte(input logic [7:0] b, input logic eoi);
		while (!steady && $urandom_range(99) < 30) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eoi;
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	task automatic send_pending();
		logic [8:0] w;
		while (pending_bytes.size() > 0) begin
			w = pending_bytes.pop_front();
			push_byte(w[7:0], w[8]);
		end
	endtask

	// stop offering until every expected word is out
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	function automatic void add_byte(input logic [8:0] w);
		pending_bytes.insert(pending_bytes.size(), w);
	endfunction

	function automatic void mark_end();
		logic [8:0] w;
		w = pending_bytes[pending_bytes.size() - 1];
		w[8] = 1'b1;
		pending_bytes[pending_bytes.size() - 1] = w;
	endfunction

	// encoding of a random code point of the given byte length (the three-byte range includes surrogates)
	function automatic void add_scalar(input int len);
		logic [20:0] cp;
		int unsigned lo, hi, pick;
		case (len)
			1: begin lo = 0; hi = 'h7F; end
			2: begin lo = 'h80; hi = 'h7FF; end
			3: begin lo = 'h800; hi = 'hFFFF; end
			default: begin lo = 'h10000; hi = 'h10FFFF; end
		endcase
		pick = $urandom_range(9);
		if (pick == 0) cp = 21'(lo);
		else if (pick == 1) cp = 21'(hi);
		else cp = 21'($urandom_range(hi, lo));
		case (len)
			1: add_byte({1'b0, cp[7:0]});
			2: begin
				add_byte({1'b0, 3'b110, cp[10:6]});
				add_byte({1'b0, 2'b10, cp[5:0]});
			end
			3: begin
				add_byte({1'b0, 4'b1110, cp[15:12]});
				add_byte({1'b0, 2'b10, cp[11:6]});
				add_byte({1'b0, 2'b10, cp[5:0]});
			end
			default: begin
				add_byte({1'b0, 5'b11110, cp[20:18]});
				add_byte({1'b0, 2'b10, cp[17:12]});
				add_byte({1'b0, 2'b10, cp[11:6]});
				add_byte({1'b0, 2'b10, cp[5:0]});
			end
		endcase
	endfunction

	// mostly valid text, some broken sequences, some raw noise
	task automatic random_run(input int n_items);
		int         target, kind, len, pos;
		logic [7:0] junk, lead;
		target = sent + n_items;
		while (sent < target) begin
			kind = $urandom_range(99);
			if (kind < 70) begin
				add_scalar($urandom_range(1, 4));
				if ($urandom_range(19) == 0) mark_end();
			end else if (kind < 85) begin
				len = $urandom_range(2, 4);
				case ($urandom_range(2))
					// cut short, sometimes at the end of the buffer
					0: begin
						add_scalar(len);
						repeat ($urandom_range(1, len - 1))
							pending_bytes.delete(pending_bytes.size() - 1);
						if ($urandom_range(1)) mark_end();
					end
					// a continuation replaced by a byte that is not 10xxxxxx
					1: begin
						add_scalar(len);
						pos  = $urandom_range(1, len - 1);
						junk = 8'($urandom_range(255));
						if (junk[7:6] == 2'b10) junk[6] = 1'b1;
						pending_bytes[pos] = {1'b0, junk};
					end
					// E0, ED, F0 and F4 leads, second byte anywhere in 80..BF
					default: begin
						case ($urandom_range(3))
							0: lead = Lead3;
							1: lead = 8'hED;
							2: lead = Lead4;
							default: lead = LeadF4;
						endcase
						add_byte({1'b0, lead});
						repeat ((lead >= Lead4) ? 3 : 2)
							add_byte({1'b0, 8'($urandom_range(8'hBF, 8'h80))});
					end
				endcase
			end else begin
				junk = 8'($urandom_range(255));
				add_byte({($urandom_range(9) == 0), junk});
			end
			send_pending();
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		pending_bytes = '{
			9'h000, 9'h07F,                 // ASCII extremes
			9'h080, 9'h0C1, 9'h0F5, 9'h1FF, // bad leads, last one ends the buffer
			9'h0C2, 9'h080, 9'h0DF, 9'h0BF, // two-byte range ends
			9'h0E0, 9'h0A0, 9'h080,         // shortest legal three-byte form
			9'h0ED, 9'h0BF, 9'h0BF,         // surrogate goes through as a scalar
			9'h0F4, 9'h08F, 9'h0BF, 9'h0BF, // U+10FFFF
			9'h0E0, 9'h09F,                 // overlong after E0
			9'h0F0, 9'h08F,                 // overlong after F0
			9'h0F4, 9'h090,                 // beyond U+10FFFF
			9'h0C2, 9'h041,                 // continuation that is plain ASCII
			9'h0F1, 9'h080, 9'h080, 9'h041, // three escapes then 'A': four words
			9'h0E1, 9'h180                  // buffer ends mid-sequence
		};
		send_pending();
		drain();

		hold_off_req = 1'b1;
		random_run(150);
		drain();

		steady = 1'b1;
		random_run(100);
		steady = 1'b0;

		random_run(470 - sent);
		drain();
		repeat (8) @(posedge clk);

		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
